// File: rtl/core/xlfr_pkg.sv
// Package of shared types and constants for the XOR LRC frame receiver.
`timescale 1ns / 1ps

package xlfr_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h7E;
    localparam logic [7:0] MIN_LEN   = 8'd4;
    localparam logic [7:0] HEAD_LEN  = 8'd3;

    typedef enum logic [2:0] {
        ST_DATA      = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_SYNC  = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_CHECK = 3'd4
    } t_status;

    typedef enum logic [5:0] {
        PH_SYNC1 = 6'b000001,
        PH_SYNC2 = 6'b000010,
        PH_LEN   = 6'b000100,
        PH_ID    = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_CHECK = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [7:0] station_id;
        logic [7:0] byte_index;
        logic       frame_end;
        t_status    status;
    } t_result;

endpackage

// File: rtl/core/xor_lrc_frame_receiver.sv
// Frame receiver: byte-serial deframer with double sync, length, id and XOR check.
//
// Input channel: one received byte per request on i_byte_in, qualified by
// i_in_valid; the block holds it off with o_in_stall.
// Output channel: at most one result per input byte on o_byte_out, o_station_id,
// o_byte_index, o_frame_end and o_status, qualified by o_out_valid and held
// off by the downstream i_out_stall.
// Each payload byte yields a data result; the check byte closes the frame with
// an ok or bad-check status, and a bad sync or a length below four yields an
// error result after which the block hunts for sync again.
// Throughput is one byte per cycle while o_in_stall is low, set by the
// combinational parse state update between the accepted byte and the result
// register; while the downstream stalls, a result lands in the skid instead.
// A skid register behind the result register lets one further result land
// while the downstream stalls; o_in_stall rises only when that skid is full.
// Synchronous active-low reset returns the parser to hunting for the first sync
// byte and empties both result registers.
`timescale 1ns / 1ps

module xor_lrc_frame_receiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_byte_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_byte_out,
    output logic [7:0]        o_station_id,
    output logic [7:0]        o_byte_index,
    output logic              o_frame_end,
    output logic [2:0]        o_status
);
    import xlfr_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_running_xor, n_running_xor;
    logic [7:0] r_held_id, n_held_id;
    logic [7:0] r_payload_pos, n_payload_pos;

    t_result    r_out, r_skid, n_res;
    logic       r_out_valid, r_skid_valid, n_res_valid;

    logic       in_accept;
    logic       out_take;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    // Parse step for the byte on the input port.
    always_comb begin
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_running_xor = r_running_xor;
        n_held_id     = r_held_id;
        n_payload_pos = r_payload_pos;
        n_res_valid   = 1'b0;
        n_res         = '{byte_out: i_byte_in, station_id: 8'd0, byte_index: 8'd0,
                          frame_end: 1'b1, status: ST_BAD_SYNC};
        case (r_phase)
            PH_SYNC2: begin
                if (i_byte_in != SYNC_BYTE) begin
                    n_phase     = PH_SYNC1;
                    n_res_valid = 1'b1;
                end else begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_byte_in < MIN_LEN) begin
                    n_phase      = PH_SYNC1;
                    n_res_valid  = 1'b1;
                    n_res.status = ST_BAD_LEN;
                end else begin
                    n_running_xor = i_byte_in;
                    n_bytes_left  = i_byte_in - HEAD_LEN;
                    n_phase       = PH_ID;
                end
            end
            PH_ID: begin
                n_held_id     = i_byte_in;
                n_running_xor = r_running_xor ^ i_byte_in;
                n_payload_pos = 8'd0;
                n_phase       = (r_bytes_left == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                n_running_xor    = r_running_xor ^ i_byte_in;
                n_payload_pos    = r_payload_pos + 8'd1;
                n_bytes_left     = r_bytes_left - 8'd1;
                if (r_bytes_left == 8'd1) begin
                    n_phase = PH_CHECK;
                end
                n_res_valid      = 1'b1;
                n_res.station_id = r_held_id;
                n_res.byte_index = r_payload_pos;
                n_res.frame_end  = 1'b0;
                n_res.status     = ST_DATA;
            end
            PH_CHECK: begin
                n_phase          = PH_SYNC1;
                n_res_valid      = 1'b1;
                n_res.station_id = r_held_id;
                n_res.status     = (i_byte_in == r_running_xor) ? ST_OK : ST_BAD_CHECK;
            end
            default: begin
                if (i_byte_in != SYNC_BYTE) begin
                    n_phase     = PH_SYNC1;
                    n_res_valid = 1'b1;
                end else begin
                    n_phase = PH_SYNC2;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC1;
            r_bytes_left  <= 8'd0;
            r_running_xor <= 8'd0;
            r_held_id     <= 8'd0;
            r_payload_pos <= 8'd0;
        end else if (in_accept) begin
            r_phase       <= n_phase;
            r_bytes_left  <= n_bytes_left;
            r_running_xor <= n_running_xor;
            r_held_id     <= n_held_id;
            r_payload_pos <= n_payload_pos;
        end
    end

    // Result register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= in_accept && n_res_valid;
        end else if (in_accept && n_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            if (in_accept && n_res_valid) begin
                r_out <= n_res;
            end
        end else if (in_accept && n_res_valid) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_out   = r_out.byte_out;
    assign o_station_id = r_out.station_id;
    assign o_byte_index = r_out.byte_index;
    assign o_frame_end  = r_out.frame_end;
    assign o_status     = r_out.status;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_data_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DATA) |-> !o_frame_end)
        else $error("payload result marked as frame end");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_BAD_SYNC || o_status == ST_BAD_LEN))
        |-> (o_station_id == 8'd0 && o_byte_index == 8'd0 && o_frame_end))
        else $error("error result carries stale frame fields");

    a_last_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_DATA && r_bytes_left == 8'd1)
        |=> r_phase == PH_CHECK)
        else $error("parser did not move to the check byte after the last payload byte");
`endif

endmodule
